[src/rdz_pkg.sv]
// rdz_pkg: shared constants for the radial deadzone scaler
// no dependencies; used by the top level and the testbench
package rdz_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int GUARD           = 8;
  localparam int DZ_BITS         = 15;
  localparam int DZ_REF_BITS     = DZ_BITS + 1;

  localparam logic [DZ_BITS-1:0] DZ_RESET = 15'd3277;

endpackage

[src/radial_deadzone_scaler.sv]
// radial_deadzone_scaler: radial or one-sided deadzone with rescale, one item per cycle while not stalled
// stages: input, squares, deadzone test, the square root chain (SAMPLE_BITS+8 cells),
// numerator and denominator, saturation test and the divider chain (SAMPLE_BITS-1 cells),
// then a two-entry output queue; throughput one item per cycle while in_stall is low
// synchronous reset empties the pipeline and output queue, deadzone returns to 3277
// uses rdz_pkg, rdz_sqrt_cell, rdz_div_cell
module radial_deadzone_scaler #(
  parameter int SAMPLE_BITS = rdz_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] axis_sample,
  input  logic signed [SAMPLE_BITS-1:0] partner_value,
  input  logic                          is_stick_axis,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] conditioned_value,
  input  logic                          cfg_we,
  input  logic [rdz_pkg::DZ_BITS-1:0]   cfg_wdata
);

  localparam int F   = SAMPLE_BITS - 1;
  localparam int G   = rdz_pkg::GUARD;
  localparam int K   = F + G + 1;
  localparam int W   = 2 * K;
  localparam int SQW = 2 * F + 2;
  localparam int AW  = 2 * F + G + 2;
  localparam int PW1 = 3 + (F + 1) + F;
  localparam int PW2 = 3;
  localparam logic [K-1:0] ONEG = K'(1) << (F + G);
  localparam logic [F:0]   ONE  = (F+1)'(1) << F;
  localparam logic [F-1:0] LIM  = {F{1'b1}};

  logic [rdz_pkg::DZ_BITS-1:0] deadzone;
  logic [F-1:0]                dz_f;
  logic                        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= rdz_pkg::DZ_RESET;
    end else if (cfg_we) begin
      deadzone <= cfg_wdata;
    end
  end

  generate
    if (SAMPLE_BITS >= rdz_pkg::DZ_REF_BITS) begin : g_dz_wide
      assign dz_f = F'(deadzone) << (SAMPLE_BITS - rdz_pkg::DZ_REF_BITS);
    end else begin : g_dz_narrow
      assign dz_f = deadzone[rdz_pkg::DZ_BITS-1 -: F];
    end
  endgenerate

  // input stage
  logic       v0;
  logic [F:0] x0;
  logic [F:0] p0;
  logic       st0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= axis_sample;
      p0  <= partner_value;
      st0 <= is_stick_axis;
    end
  end

  // squares
  logic [F:0]     ax0;
  logic [F:0]     ap0;
  logic           lin_pos0;
  logic [F-1:0]   lin_a0;
  logic           v1;
  logic [SQW-1:0] sqx1;
  logic [SQW-1:0] sqp1;
  logic [2*F-1:0] dz2_1;
  logic [F:0]     ax1;
  logic           neg1;
  logic           st1;
  logic           linz1;
  logic [F-1:0]   lina1;

  assign ax0      = x0[F] ? (~x0 + (F+1)'(1)) : x0;
  assign ap0      = p0[F] ? (~p0 + (F+1)'(1)) : p0;
  assign lin_pos0 = !x0[F] && (x0[F-1:0] > dz_f);
  assign lin_a0   = x0[F-1:0] - dz_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx1  <= SQW'(ax0) * SQW'(ax0);
      sqp1  <= SQW'(ap0) * SQW'(ap0);
      dz2_1 <= (2*F)'(dz_f) * (2*F)'(dz_f);
      ax1   <= ax0;
      neg1  <= st0 & x0[F];
      st1   <= st0;
      linz1 <= !lin_pos0;
      lina1 <= lin_a0;
    end
  end

  // squared magnitude and deadzone test
  logic [SQW-1:0] m2_1;
  logic           zero1;
  logic           v2;
  logic [W-1:0]   rad2;
  logic [PW1-1:0] data2;

  assign m2_1  = sqx1 + sqp1;
  assign zero1 = st1 ? (m2_1 <= {2'b00, dz2_1}) : linz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad2  <= {m2_1, {(2*G){1'b0}}};
      data2 <= {st1, neg1, zero1, ax1, lina1};
    end
  end

  // square root chain
  logic           sq_valid [0:K];
  logic [K:0]     sq_rem   [0:K];
  logic [K-1:0]   sq_root  [0:K];
  logic [W-1:0]   sq_rad   [0:K];
  logic [PW1-1:0] sq_data  [0:K];

  assign sq_valid[0] = v2;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_rad[0]   = rad2;
  assign sq_data[0]  = data2;

  generate
    for (genvar i = 0; i < K; i++) begin : g_sqrt
      rdz_sqrt_cell #(.K(K), .PW(PW1)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .up_valid (sq_valid[i]),
        .up_rem   (sq_rem[i]),
        .up_root  (sq_root[i]),
        .up_rad   (sq_rad[i]),
        .up_data  (sq_data[i]),
        .dn_valid (sq_valid[i+1]),
        .dn_rem   (sq_rem[i+1]),
        .dn_root  (sq_root[i+1]),
        .dn_rad   (sq_rad[i+1]),
        .dn_data  (sq_data[i+1])
      );
    end
  endgenerate

  // numerator and denominator
  logic           st_s;
  logic           neg_s;
  logic           zero_s;
  logic [F:0]     ax_s;
  logic [F-1:0]   lina_s;
  logic [K-1:0]   m_s;
  logic [K-1:0]   dg_s;
  logic [K-1:0]   mdg_s;
  logic [AW-1:0]  prod_a;
  logic [W-1:0]   prod_d;
  logic           v3;
  logic [W-1:0]   num3;
  logic [W-1:0]   den3;
  logic           neg3;
  logic           zero3;

  assign {st_s, neg_s, zero_s, ax_s, lina_s} = sq_data[K];
  assign m_s    = sq_root[K];
  assign dg_s   = K'({dz_f, {G{1'b0}}});
  assign mdg_s  = m_s - dg_s;
  assign prod_a = AW'(ax_s) * AW'(mdg_s);
  assign prod_d = W'(ONEG - dg_s) * W'(m_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= sq_valid[K];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3  <= st_s ? {prod_a, {G{1'b0}}} : W'(lina_s);
      den3  <= st_s ? prod_d : W'(ONE - {1'b0, dz_f});
      neg3  <= neg_s;
      zero3 <= zero_s;
    end
  end

  // saturation test
  logic         v4;
  logic [W-1:0] num4;
  logic [W-1:0] den4;
  logic [PW2-1:0] data4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num4  <= num3;
      den4  <= den3;
      data4 <= {neg3, zero3, num3 >= den3};
    end
  end

  // divider chain
  logic           dv_valid [0:F];
  logic [W-1:0]   dv_rem   [0:F];
  logic [W-1:0]   dv_den   [0:F];
  logic [F-1:0]   dv_quo   [0:F];
  logic [PW2-1:0] dv_data  [0:F];

  assign dv_valid[0] = v4;
  assign dv_rem[0]   = num4;
  assign dv_den[0]   = den4;
  assign dv_quo[0]   = '0;
  assign dv_data[0]  = data4;

  generate
    for (genvar j = 0; j < F; j++) begin : g_div
      rdz_div_cell #(.W(W), .QW(F), .PW(PW2)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .up_valid (dv_valid[j]),
        .up_rem   (dv_rem[j]),
        .up_den   (dv_den[j]),
        .up_quo   (dv_quo[j]),
        .up_data  (dv_data[j]),
        .dn_valid (dv_valid[j+1]),
        .dn_rem   (dv_rem[j+1]),
        .dn_den   (dv_den[j+1]),
        .dn_quo   (dv_quo[j+1]),
        .dn_data  (dv_data[j+1])
      );
    end
  endgenerate

  // result and output queue
  logic       neg_e;
  logic       zero_e;
  logic       sat_e;
  logic [F-1:0] mag_e;
  logic [F:0] res_e;
  logic       push;
  logic       pop;
  logic [F:0] fifo [0:1];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign {neg_e, zero_e, sat_e} = dv_data[F];
  assign mag_e = zero_e ? '0 : (sat_e ? LIM : dv_quo[F]);
  assign res_e = neg_e ? (~{1'b0, mag_e} + (F+1)'(1)) : {1'b0, mag_e};

  assign en        = (count != 2'd2);
  assign in_stall  = !en;
  assign push      = en && dv_valid[F];
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign conditioned_value = fifo[rptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= res_e;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == 2'd2))
    else $error("item pushed into full output queue");

  a_no_min_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (conditioned_value != {1'b1, {F{1'b0}}}))
    else $error("result outside saturation range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

[src/rdz_sqrt_cell.sv]
// rdz_sqrt_cell: one radicand digit pair of the pipelined square root
// standalone cell; chained by radial_deadzone_scaler
module rdz_sqrt_cell #(
  parameter int K  = 24,
  parameter int PW = 34
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            up_valid,
  input  logic [K:0]      up_rem,
  input  logic [K-1:0]    up_root,
  input  logic [2*K-1:0]  up_rad,
  input  logic [PW-1:0]   up_data,
  output logic            dn_valid,
  output logic [K:0]      dn_rem,
  output logic [K-1:0]    dn_root,
  output logic [2*K-1:0]  dn_rad,
  output logic [PW-1:0]   dn_data
);

  logic [K+2:0] r_sh;
  logic [K+2:0] trial;
  logic [K+2:0] diff;
  logic         ge;

  assign r_sh  = {up_rem, up_rad[2*K-1 -: 2]};
  assign trial = {1'b0, up_root, 2'b01};
  assign ge    = r_sh >= trial;
  assign diff  = r_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_rem  <= ge ? diff[K:0] : r_sh[K:0];
      dn_root <= {up_root[K-2:0], ge};
      dn_rad  <= {up_rad[2*K-3:0], 2'b00};
      dn_data <= up_data;
    end
  end

endmodule

[src/rdz_div_cell.sv]
// rdz_div_cell: one quotient bit of the pipelined restoring divider
// standalone cell; chained by radial_deadzone_scaler
module rdz_div_cell #(
  parameter int W  = 48,
  parameter int QW = 15,
  parameter int PW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          up_valid,
  input  logic [W-1:0]  up_rem,
  input  logic [W-1:0]  up_den,
  input  logic [QW-1:0] up_quo,
  input  logic [PW-1:0] up_data,
  output logic          dn_valid,
  output logic [W-1:0]  dn_rem,
  output logic [W-1:0]  dn_den,
  output logic [QW-1:0] dn_quo,
  output logic [PW-1:0] dn_data
);

  logic [W:0] r2;
  logic [W:0] diff;
  logic       ge;

  assign r2   = {up_rem, 1'b0};
  assign ge   = r2 >= {1'b0, up_den};
  assign diff = r2 - {1'b0, up_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_rem  <= ge ? diff[W-1:0] : r2[W-1:0];
      dn_den  <= up_den;
      dn_quo  <= {up_quo[QW-2:0], ge};
      dn_data <= up_data;
    end
  end

endmodule

[test/radial_deadzone_scaler_tb.sv]
// radial_deadzone_scaler_tb: self-checking bench for the radial deadzone scaler
// drives a directed table, then random items over several deadzone settings,
// and checks each output item against a table value or a bit-exact predictor; needs rdz_pkg
module radial_deadzone_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = rdz_pkg::SAMPLE_BITS_DEF;
  localparam int FRACB = SB - 1;
  localparam longint unsigned ONE_Q = 64'd1 << FRACB;
  localparam longint unsigned SAT_MAG = ONE_Q - 1;
  localparam int WDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * SB + 40;

  typedef struct {
    logic signed [SB-1:0] axis;
    logic signed [SB-1:0] partner;
    logic                 stick;
    bit                   typed;
    logic signed [SB-1:0] want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SB-1:0]        axis_sample = '0;
  logic signed [SB-1:0]        partner_value = '0;
  logic                        is_stick_axis = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SB-1:0]        conditioned_value;
  logic                        cfg_we = 1'b0;
  logic [rdz_pkg::DZ_BITS-1:0] cfg_wdata = '0;

  logic signed [SB-1:0]        scaled_q[$];
  logic [rdz_pkg::DZ_BITS-1:0] dz_model = rdz_pkg::DZ_RESET;
  bit                          failed = 0;
  bit                          calm = 0;
  int                          idle_cycles = 0;

  radial_deadzone_scaler #(.SAMPLE_BITS(SB)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .axis_sample(axis_sample), .partner_value(partner_value),
    .is_stick_axis(is_stick_axis),
    .out_valid(out_valid), .out_stall(out_stall),
    .conditioned_value(conditioned_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned frac_div_sat(longint unsigned a, longint unsigned den,
                                                   int sh);
    longint unsigned q;
    longint unsigned r;
    q = a / den;
    r = a % den;
    if (q > SAT_MAG) return SAT_MAG;
    for (int i = 0; i < sh; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
      if (q > SAT_MAG) return SAT_MAG;
    end
    return q;
  endfunction

  function automatic logic signed [SB-1:0] predict_scaled(logic signed [SB-1:0] x,
                                                          logic signed [SB-1:0] p,
                                                          logic stick,
                                                          logic [rdz_pkg::DZ_BITS-1:0] dz);
    longint signed   xs;
    longint signed   ps;
    longint unsigned ax;
    longint unsigned ap;
    longint unsigned df;
    longint unsigned m2;
    longint unsigned m;
    longint unsigned dg;
    longint unsigned mag;
    bit              neg;
    xs = x;
    ps = p;
    df = longint'(dz) << (SB - 16);
    mag = 0;
    neg = 0;
    if (stick) begin
      ax = (xs < 0) ? -xs : xs;
      ap = (ps < 0) ? -ps : ps;
      m2 = ax * ax + ap * ap;
      if (m2 > df * df) begin
        m = int_sqrt(m2 << (2 * rdz_pkg::GUARD));
        dg = df << rdz_pkg::GUARD;
        mag = frac_div_sat(ax * (m - dg), ((ONE_Q << rdz_pkg::GUARD) - dg) * m,
                           FRACB + rdz_pkg::GUARD);
        neg = xs < 0;
      end
    end else if (xs > longint'(df)) begin
      mag = frac_div_sat(longint'(xs) - df, ONE_Q - df, FRACB);
    end
    return neg ? -mag[SB-1:0] : mag[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    int mode;
    int d;
    mode = $urandom_range(0, 9);
    d = int'(dz_model);
    if (mode < 4) return SB'($urandom);
    if (mode < 7) return SB'(d + $signed($urandom_range(0, 400)) - 200);
    if (mode == 7) return SB'(-d + $signed($urandom_range(0, 400)) - 200);
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh8001;
      3: return '0;
      default: return SB'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic send_item(logic signed [SB-1:0] x, logic signed [SB-1:0] p, logic stick,
                           bit typed, logic signed [SB-1:0] want);
    int gap;
    bit st;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    axis_sample <= x;
    partner_value <= p;
    is_stick_axis <= stick;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    scaled_q.push_back(typed ? want : predict_scaled(x, p, stick, dz_model));
  endtask

  task automatic write_deadzone(logic [rdz_pkg::DZ_BITS-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (scaled_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dz_model = v;
  endtask

  initial begin
    forever begin
      int n;
      n = calm ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (scaled_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0d", $time,
                   conditioned_value);
          failed = 1;
        end else begin
          logic signed [SB-1:0] want;
          want = scaled_q.pop_front();
          if (conditioned_value !== want) begin
            $display("%0t: conditioned_value mismatch, expected %0d, actual %0d", $time,
                     want, conditioned_value);
            failed = 1;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  stim_row_t rows[] = '{
    '{16'sd0,      16'sd0,      1'b1, 1'b1, 16'sd0},
    '{16'sd0,      16'sd0,      1'b0, 1'b1, 16'sd0},
    '{16'sh8000,   16'sd0,      1'b0, 1'b1, 16'sd0},
    '{16'sh8000,   16'sd100,    1'b0, 1'b1, 16'sd0},
    '{16'sd3277,   16'sh7fff,   1'b0, 1'b1, 16'sd0},
    '{16'sd3277,   16'sd0,      1'b1, 1'b1, 16'sd0},
    '{16'sd0,      -16'sd3277,  1'b1, 1'b1, 16'sd0},
    '{16'sh8000,   16'sd0,      1'b1, 1'b1, -16'sd32767},
    '{16'sh7fff,   16'sh7fff,   1'b1, 1'b1, 16'sd32767},
    '{16'sh8000,   16'sh8000,   1'b1, 1'b1, -16'sd32767},
    '{16'sd0,      16'sh7fff,   1'b1, 1'b1, 16'sd0},
    '{16'sh7fff,   16'sd0,      1'b0, 1'b0, 16'sd0},
    '{16'sd3278,   16'sd0,      1'b0, 1'b0, 16'sd0},
    '{16'sd3278,   16'sd0,      1'b1, 1'b0, 16'sd0},
    '{16'sd2318,   16'sd2318,   1'b1, 1'b0, 16'sd0},
    '{-16'sd2318,  16'sd2318,   1'b1, 1'b0, 16'sd0},
    '{16'sh7fff,   16'sd0,      1'b1, 1'b0, 16'sd0},
    '{16'sd16384,  -16'sd5000,  1'b1, 1'b0, 16'sd0},
    '{-16'sd16384, -16'sd5000,  1'b1, 1'b0, 16'sd0},
    '{16'sd20000,  16'sh5555,   1'b0, 1'b0, 16'sd0},
    '{16'sd1,      16'sh7fff,   1'b1, 1'b0, 16'sd0},
    '{-16'sd1,     16'sh8000,   1'b1, 1'b0, 16'sd0}
  };

  initial begin
    logic [rdz_pkg::DZ_BITS-1:0] dz_set[6];
    dz_set = '{15'd0, 15'd32766, 15'd1, 15'd16384, 15'h5555, 15'd0};
    dz_set[5] = 15'($urandom_range(0, 32766));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i])
      send_item(rows[i].axis, rows[i].partner, rows[i].stick, rows[i].typed, rows[i].want);
    foreach (dz_set[k]) begin
      write_deadzone(dz_set[k]);
      for (int i = 0; i < 80; i++) begin
        if (i % 20 == 0) calm = ($urandom_range(0, 3) == 0);
        send_item(pick_sample(), pick_sample(), $urandom_range(0, 3) != 0, 1'b0, '0);
      end
    end
    calm = 0;
    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
